// ===== rtl/armdp_pkg.sv =====
// ----------------------------------------------------------------------------
// ARM data-processing ALU package
// Opcode and shift codes, and the structs passed between the shifter, the ALU
// and the top level.
// ----------------------------------------------------------------------------
package armdp_pkg;

  typedef enum logic [3:0] {
    OPC_AND = 4'h0,
    OPC_EOR = 4'h1,
    OPC_SUB = 4'h2,
    OPC_RSB = 4'h3,
    OPC_ADD = 4'h4,
    OPC_ADC = 4'h5,
    OPC_SBC = 4'h6,
    OPC_RSC = 4'h7,
    OPC_TST = 4'h8,
    OPC_TEQ = 4'h9,
    OPC_CMP = 4'hA,
    OPC_CMN = 4'hB,
    OPC_ORR = 4'hC,
    OPC_MOV = 4'hD,
    OPC_BIC = 4'hE,
    OPC_MVN = 4'hF
  } opcode_e;

  typedef enum logic [1:0] {
    SH_LSL = 2'd0,
    SH_LSR = 2'd1,
    SH_ASR = 2'd2,
    SH_ROR = 2'd3
  } shift_e;

  localparam logic [3:0] REG_PC = 4'hF;
  localparam logic [31:0] PC_AHEAD = 32'd4;

  typedef struct packed {
    logic n;
    logic z;
    logic c;
    logic v;
  } nzcv_t;

  typedef struct packed {
    logic [31:0] operand;
    logic        carry;
  } shift_res_t;

  typedef struct packed {
    logic [31:0] value;
    logic        write;
    nzcv_t       flags;
    logic        restore;
    logic        flush;
  } alu_res_t;

endpackage

// ===== rtl/arm_data_processing_alu_unit.sv =====
// ----------------------------------------------------------------------------
// ARM data-processing ALU unit
// Channel  Direction  Handshake                  Word
// in       input      in_valid_i / in_stall_o    instruction, Rn, Rm, Rs byte, NZCV
// out      output     out_valid_o / out_stall_i  result, write, NZCV, r15 markers
//
// One word per cycle while the output is not stalled.
// Input register, then shifter and adder in one stage, then result register.
// Reset clears both valid bits; payload registers are not reset.
// Output stall holds the result; the input is stalled only when both
// registers are full and the output is stalled.
// ----------------------------------------------------------------------------
module arm_data_processing_alu_unit
  import armdp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] instruction_word_i,
  input  logic [31:0] first_operand_value_i,
  input  logic [31:0] second_operand_value_i,
  input  logic [7:0]  shift_register_value_i,
  input  logic        negative_in_i,
  input  logic        zero_in_i,
  input  logic        carry_in_i,
  input  logic        overflow_in_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] result_value_o,
  output logic        write_result_o,
  output logic        flag_n_o,
  output logic        flag_z_o,
  output logic        flag_c_o,
  output logic        flag_v_o,
  output logic        restore_saved_status_o,
  output logic        flush_pipeline_o
);

  logic        in_valid_q;
  logic        out_valid_q;
  logic        out_ready;
  logic        in_load;
  logic        out_load;
  logic [31:0] instr_q;
  logic [31:0] rn_q;
  logic [31:0] rm_q;
  logic [7:0]  rs_q;
  nzcv_t       flags_q;
  shift_res_t  shift_res;
  alu_res_t    alu_res;
  alu_res_t    res_q;

  assign out_ready  = !out_valid_q || !out_stall_i;
  assign in_stall_o = in_valid_q && !out_ready;
  assign in_load    = in_valid_i && !in_stall_o;
  assign out_load   = in_valid_q && out_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (!in_stall_o) begin
        in_valid_q <= in_valid_i;
      end
      if (out_ready) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load) begin
      instr_q <= instruction_word_i;
      rn_q    <= first_operand_value_i;
      rm_q    <= second_operand_value_i;
      rs_q    <= shift_register_value_i;
      flags_q <= '{n: negative_in_i, z: zero_in_i, c: carry_in_i, v: overflow_in_i};
    end
    if (out_load) begin
      res_q <= alu_res;
    end
  end

  armdp_shifter u_shifter (
    .instr_i (instr_q),
    .rm_i    (rm_q),
    .rs_i    (rs_q),
    .carry_i (flags_q.c),
    .shift_o (shift_res)
  );

  armdp_alu u_alu (
    .instr_i (instr_q),
    .rn_i    (rn_q),
    .shift_i (shift_res),
    .flags_i (flags_q),
    .res_o   (alu_res)
  );

  assign out_valid_o            = out_valid_q;
  assign result_value_o         = res_q.value;
  assign write_result_o         = res_q.write;
  assign flag_n_o               = res_q.flags.n;
  assign flag_z_o               = res_q.flags.z;
  assign flag_c_o               = res_q.flags.c;
  assign flag_v_o               = res_q.flags.v;
  assign restore_saved_status_o = res_q.restore;
  assign flush_pipeline_o       = res_q.flush;

endmodule

// ===== rtl/armdp_shifter.sv =====
// ----------------------------------------------------------------------------
// ARM data-processing operand shifter
// Builds the second operand: a rotated 8-bit immediate or Rm through the
// barrel shifter, with the shifter carry out.
// ----------------------------------------------------------------------------
module armdp_shifter
  import armdp_pkg::*;
(
  input  logic [31:0] instr_i,
  input  logic [31:0] rm_i,
  input  logic [7:0]  rs_i,
  input  logic        carry_i,
  output shift_res_t  shift_o
);

  logic        by_reg;
  logic [31:0] v;
  logic [4:0]  amt;
  logic        amt_big;
  logic        amt_zero;
  logic [4:0]  lidx;
  logic [4:0]  ridx;
  logic [63:0] rot_full;
  logic [4:0]  imm_rot;
  logic [63:0] imm_full;
  shift_e      sh_type;

  assign by_reg   = instr_i[4];
  assign sh_type  = shift_e'(instr_i[6:5]);
  assign v        = (by_reg && instr_i[3:0] == REG_PC) ? rm_i + PC_AHEAD : rm_i;
  assign amt      = by_reg ? rs_i[4:0] : instr_i[11:7];
  assign amt_big  = by_reg && (rs_i[7:5] != 3'd0);
  assign amt_zero = by_reg ? (rs_i == 8'd0) : (instr_i[11:7] == 5'd0);
  assign lidx     = 5'(6'd32 - {1'b0, amt});
  assign ridx     = amt - 5'd1;
  assign rot_full = {v, v} >> amt;
  assign imm_rot  = {instr_i[11:8], 1'b0};
  assign imm_full = {24'd0, instr_i[7:0], 24'd0, instr_i[7:0]} >> imm_rot;

  always_comb begin
    shift_o.operand = v;
    shift_o.carry   = carry_i;
    if (instr_i[25]) begin
      shift_o.operand = imm_full[31:0];
      if (imm_rot != 5'd0) begin
        shift_o.carry = imm_full[31];
      end
    end else if (by_reg) begin
      if (!amt_zero) begin
        unique case (sh_type)
          SH_LSL: begin
            if (!amt_big) begin
              shift_o.operand = v << amt;
              shift_o.carry   = v[lidx];
            end else begin
              shift_o.operand = '0;
              shift_o.carry   = (rs_i == 8'd32) ? v[0] : 1'b0;
            end
          end
          SH_LSR: begin
            if (!amt_big) begin
              shift_o.operand = v >> amt;
              shift_o.carry   = v[ridx];
            end else begin
              shift_o.operand = '0;
              shift_o.carry   = (rs_i == 8'd32) ? v[31] : 1'b0;
            end
          end
          SH_ASR: begin
            if (!amt_big) begin
              shift_o.operand = 32'($signed(v) >>> amt);
              shift_o.carry   = v[ridx];
            end else begin
              shift_o.operand = {32{v[31]}};
              shift_o.carry   = v[31];
            end
          end
          SH_ROR: begin
            if (amt == 5'd0) begin
              shift_o.operand = v;
              shift_o.carry   = v[31];
            end else begin
              shift_o.operand = rot_full[31:0];
              shift_o.carry   = v[ridx];
            end
          end
          default: ;
        endcase
      end
    end else begin
      unique case (sh_type)
        SH_LSL: begin
          if (!amt_zero) begin
            shift_o.operand = v << amt;
            shift_o.carry   = v[lidx];
          end
        end
        SH_LSR: begin
          if (amt_zero) begin
            shift_o.operand = '0;
            shift_o.carry   = v[31];
          end else begin
            shift_o.operand = v >> amt;
            shift_o.carry   = v[ridx];
          end
        end
        SH_ASR: begin
          if (amt_zero) begin
            shift_o.operand = {32{v[31]}};
            shift_o.carry   = v[31];
          end else begin
            shift_o.operand = 32'($signed(v) >>> amt);
            shift_o.carry   = v[ridx];
          end
        end
        SH_ROR: begin
          if (amt_zero) begin
            shift_o.operand = {carry_i, v[31:1]};
            shift_o.carry   = v[0];
          end else begin
            shift_o.operand = rot_full[31:0];
            shift_o.carry   = v[ridx];
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/armdp_alu.sv =====
// ----------------------------------------------------------------------------
// ARM data-processing ALU core
// Runs one of the sixteen opcodes on Rn and the shifted operand and forms
// the result, the write enable, the new flags and the r15 markers.
// ----------------------------------------------------------------------------
module armdp_alu
  import armdp_pkg::*;
(
  input  logic [31:0] instr_i,
  input  logic [31:0] rn_i,
  input  shift_res_t  shift_i,
  input  nzcv_t       flags_i,
  output alu_res_t    res_o
);

  opcode_e     opc;
  logic [31:0] op1;
  logic [31:0] op2;
  logic [31:0] add_a;
  logic [31:0] add_b;
  logic        add_ci;
  logic [32:0] sum;
  logic        add_v;
  logic        arith;
  logic        compare;
  logic        dst_pc;
  logic        s_bit;
  logic [31:0] value;

  assign opc     = opcode_e'(instr_i[24:21]);
  assign s_bit   = instr_i[20];
  assign dst_pc  = instr_i[15:12] == REG_PC;
  assign compare = instr_i[24:23] == 2'b10;
  assign op2     = shift_i.operand;
  assign op1     = (!instr_i[25] && instr_i[4] && instr_i[19:16] == REG_PC)
                   ? rn_i + PC_AHEAD : rn_i;

  always_comb begin
    add_a  = op1;
    add_b  = op2;
    add_ci = 1'b0;
    arith  = 1'b0;
    value  = '0;
    unique case (opc)
      OPC_AND, OPC_TST: value = op1 & op2;
      OPC_EOR, OPC_TEQ: value = op1 ^ op2;
      OPC_SUB, OPC_CMP: begin
        add_b = ~op2; add_ci = 1'b1; arith = 1'b1;
      end
      OPC_RSB: begin
        add_a = op2; add_b = ~op1; add_ci = 1'b1; arith = 1'b1;
      end
      OPC_ADD, OPC_CMN: arith = 1'b1;
      OPC_ADC: begin
        add_ci = flags_i.c; arith = 1'b1;
      end
      OPC_SBC: begin
        add_b = ~op2; add_ci = flags_i.c; arith = 1'b1;
      end
      OPC_RSC: begin
        add_a = op2; add_b = ~op1; add_ci = flags_i.c; arith = 1'b1;
      end
      OPC_ORR: value = op1 | op2;
      OPC_MOV: value = op2;
      OPC_BIC: value = op1 & ~op2;
      OPC_MVN: value = ~op2;
      default: ;
    endcase
  end

  assign sum   = {1'b0, add_a} + {1'b0, add_b} + {32'd0, add_ci};
  assign add_v = (add_a[31] ^ sum[31]) & (add_b[31] ^ sum[31]);

  always_comb begin
    res_o.value   = arith ? sum[31:0] : value;
    res_o.write   = !compare;
    res_o.flags   = flags_i;
    res_o.restore = dst_pc && s_bit;
    res_o.flush   = dst_pc;
    if (compare || (s_bit && !dst_pc)) begin
      res_o.flags.n = res_o.value[31];
      res_o.flags.z = res_o.value == 32'd0;
      if (arith) begin
        res_o.flags.c = sum[32];
        res_o.flags.v = add_v;
      end else begin
        res_o.flags.c = shift_i.carry;
      end
    end
  end

endmodule
